// ----- src/lhm_pkg.sv -----
// ----------------------------------------------------------------------------
// lhm_pkg
// Shared types and constants for the latency histogram monitor.
// ----------------------------------------------------------------------------
package lhm_pkg;

    // Default sizing of the statistics stores
    localparam int LHM_NUM_KINDS   = 4;
    localparam int LHM_NUM_BUCKETS = 32;

    // Fixed field widths
    localparam int LHM_KIND_W     = 2;
    localparam int LHM_SEL_W      = 5;
    localparam int LHM_TIME_W     = 64;
    // Widest histogram address over the full parameter range (16 kinds x 64 buckets)
    localparam int LHM_ADDR_W_MAX = 10;

    // Depth of the front-to-back command queue
    localparam int LHM_Q_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    // One classified command handed from the front to the back
    typedef struct packed {
        t_op                       op;
        logic                      kind_ok;
        logic                      sel_ok;
        logic [LHM_KIND_W-1:0]     kind;
        logic [LHM_ADDR_W_MAX-1:0] addr;
        logic [LHM_TIME_W-1:0]     elapsed;
    } t_q_entry;

endpackage

// ----- src/lhm_front.sv -----
// ----------------------------------------------------------------------------
// lhm_front
// Accepts command beats, computes elapsed time and histogram address, drops
// records that change nothing and unused op codes, and pushes the rest into the command queue.
// ----------------------------------------------------------------------------
module lhm_front import lhm_pkg::*; #(
    parameter int NUM_KINDS   = LHM_NUM_KINDS,
    parameter int NUM_BUCKETS = LHM_NUM_BUCKETS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [1:0]            i_op,
    input  logic [LHM_KIND_W-1:0] i_kind,
    input  logic [LHM_TIME_W-1:0] i_submit_time,
    input  logic [LHM_TIME_W-1:0] i_now_time,
    input  logic [LHM_SEL_W-1:0]  i_bucket_sel,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_q_entry              o_entry,
    output logic                  o_stall
);

    localparam int DEPTH = NUM_KINDS * NUM_BUCKETS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

    // highest set bit position, 0 for values 0 and 1
    function automatic logic [6:0] f_msb(input logic [LHM_TIME_W-1:0] v);
        logic [6:0] idx;
        idx = '0;
        for (int i = 1; i < LHM_TIME_W; i++) begin
            if (v[i]) begin
                idx = 7'(i);
            end
        end
        return idx;
    endfunction

    logic                  r_vld;
    logic                  r_keep;
    logic [1:0]            r_op;
    logic                  r_kind_ok;
    logic                  r_sel_ok;
    logic [LHM_KIND_W-1:0] r_kind;
    logic [LHM_SEL_W-1:0]  r_sel;
    logic [LHM_TIME_W-1:0] r_elapsed;

    logic                  n_kind_ok;
    logic                  n_keep;
    logic [6:0]            w_msb;
    logic [6:0]            w_bkt;
    logic [6:0]            w_idx;
    logic [AW-1:0]         w_addr;
    logic                  w_drain;

    assign n_kind_ok = (int'(i_kind) < NUM_KINDS);
    assign n_keep    = ((i_op == OP_RECORD) && (i_submit_time != '0) && n_kind_ok)
                     || (i_op == OP_READ) || (i_op == OP_CLEAR);

    assign w_msb  = f_msb(r_elapsed);
    assign w_bkt  = (int'(w_msb) >= NUM_BUCKETS) ? 7'(NUM_BUCKETS - 1) : w_msb;
    assign w_idx  = (r_op == OP_RECORD) ? w_bkt : 7'(r_sel);
    assign w_addr = AW'(r_kind) * AW'(NUM_BUCKETS) + AW'(w_idx[BW-1:0]);

    assign o_stall = r_vld && r_keep && i_q_full;
    assign o_push  = r_vld && r_keep && !i_q_full;
    assign w_drain = r_vld && !o_stall;

    assign o_entry.op      = t_op'(r_op);
    assign o_entry.kind_ok = r_kind_ok;
    assign o_entry.sel_ok  = r_sel_ok;
    assign o_entry.kind    = r_kind;
    assign o_entry.addr    = LHM_ADDR_W_MAX'(w_addr);
    assign o_entry.elapsed = r_elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_accept) begin
            r_vld <= 1'b1;
        end else if (w_drain) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_keep    <= n_keep;
            r_op      <= i_op;
            r_kind_ok <= n_kind_ok;
            r_sel_ok  <= (int'(i_bucket_sel) < NUM_BUCKETS);
            r_kind    <= i_kind;
            r_sel     <= i_bucket_sel;
            r_elapsed <= (i_now_time > i_submit_time) ? (i_now_time - i_submit_time) : '0;
        end
    end

endmodule

// ----- src/lhm_queue.sv -----
// ----------------------------------------------------------------------------
// lhm_queue
// Short FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
module lhm_queue import lhm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    input  logic     i_pop,
    output t_q_entry o_entry,
    output logic     o_full,
    output logic     o_empty
);

    localparam int PW = (LHM_Q_DEPTH > 1) ? $clog2(LHM_Q_DEPTH) : 1;
    localparam int CW = $clog2(LHM_Q_DEPTH + 1);

    t_q_entry      r_mem [LHM_Q_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(LHM_Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(LHM_Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(LHM_Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

// ----- src/lhm_back.sv -----
// ----------------------------------------------------------------------------
// lhm_back
// Executes queued commands on the statistics stores: histogram memory
// read as a command is popped in idle, update or result in the execute state.
// ----------------------------------------------------------------------------
module lhm_back import lhm_pkg::*; #(
    parameter int NUM_KINDS   = LHM_NUM_KINDS,
    parameter int NUM_BUCKETS = LHM_NUM_BUCKETS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_q_entry              i_entry,
    input  logic                  i_empty,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [LHM_TIME_W-1:0] o_event_count,
    output logic [LHM_TIME_W-1:0] o_elapsed_sum,
    output logic [LHM_TIME_W-1:0] o_elapsed_max,
    output logic [LHM_TIME_W-1:0] o_bucket_count
);

    localparam int DEPTH = NUM_KINDS * NUM_BUCKETS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_bstate;

    t_bstate               r_state;
    t_q_entry              r_cur;
    logic [LHM_TIME_W-1:0] r_rd_data;
    logic                  r_rd_vld;
    logic                  r_out_vld;
    logic [LHM_TIME_W-1:0] r_cnt [NUM_KINDS];
    logic [LHM_TIME_W-1:0] r_sum [NUM_KINDS];
    logic [LHM_TIME_W-1:0] r_max [NUM_KINDS];
    logic [LHM_TIME_W-1:0] r_hist [DEPTH];
    logic [DEPTH-1:0]      r_hvld;
    logic [LHM_TIME_W-1:0] r_ev_cnt;
    logic [LHM_TIME_W-1:0] r_ev_sum;
    logic [LHM_TIME_W-1:0] r_ev_max;
    logic [LHM_TIME_W-1:0] r_bkt_cnt;

    logic [AW-1:0]         w_raddr;
    logic [AW-1:0]         w_waddr;
    logic [KW-1:0]         w_k;
    logic                  w_exec;
    logic                  w_hwe;
    logic [LHM_TIME_W-1:0] w_hist_cur;
    logic [LHM_TIME_W-1:0] w_hist_new;

    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign w_raddr    = i_entry.addr[AW-1:0];
    assign w_waddr    = r_cur.addr[AW-1:0];
    assign w_k        = KW'(r_cur.kind);
    assign w_exec     = (r_state == S_EXEC);
    assign w_hwe      = w_exec && (r_cur.op == OP_RECORD);
    // an entry never written since reset or clear reads as zero
    assign w_hist_cur = r_rd_vld ? r_rd_data : '0;
    assign w_hist_new = w_hist_cur + 1'b1;

    assign o_valid        = r_out_vld;
    assign o_event_count  = r_ev_cnt;
    assign o_elapsed_sum  = r_ev_sum;
    assign o_elapsed_max  = r_ev_max;
    assign o_bucket_count = r_bkt_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_hvld    <= '0;
            for (int k = 0; k < NUM_KINDS; k++) begin
                r_cnt[k] <= '0;
                r_sum[k] <= '0;
                r_max[k] <= '0;
            end
        end else begin
            r_out_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    case (r_cur.op)
                        OP_RECORD: begin
                            r_cnt[w_k]      <= r_cnt[w_k] + 1'b1;
                            r_sum[w_k]      <= r_sum[w_k] + r_cur.elapsed;
                            r_hvld[w_waddr] <= 1'b1;
                            if (r_cur.elapsed > r_max[w_k]) begin
                                r_max[w_k] <= r_cur.elapsed;
                            end
                        end
                        OP_READ: begin
                            r_out_vld <= 1'b1;
                        end
                        OP_CLEAR: begin
                            r_hvld <= '0;
                            for (int k = 0; k < NUM_KINDS; k++) begin
                                r_cnt[k] <= '0;
                                r_sum[k] <= '0;
                                r_max[k] <= '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // command capture, histogram memory and result registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur     <= i_entry;
            r_rd_data <= r_hist[w_raddr];
            r_rd_vld  <= r_hvld[w_raddr];
        end
        if (w_hwe) begin
            r_hist[w_waddr] <= w_hist_new;
        end
        if (w_exec && (r_cur.op == OP_READ)) begin
            r_ev_cnt  <= r_cur.kind_ok ? r_cnt[w_k] : '0;
            r_ev_sum  <= r_cur.kind_ok ? r_sum[w_k] : '0;
            r_ev_max  <= r_cur.kind_ok ? r_max[w_k] : '0;
            r_bkt_cnt <= (r_cur.kind_ok && r_cur.sel_ok) ? w_hist_cur : '0;
        end
    end

endmodule

// ----- src/latency_histogram_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// latency_histogram_monitor_unit
// Per-kind latency statistics: count, wrapping sum, max and log2 histogram.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_op/i_kind/i_submit_time/i_now_time/i_bucket_sel
//   and raise start; the beat is taken at a rising edge with start high and
//   busy low. Ops: record a latency, read one kind's statistics, clear all.
//   Result channel: a read returns one beat; o_valid is high for exactly one
//   cycle with count, sum, max and the selected bucket count. Records and
//   clears return nothing. The receiver cannot stall, so results are never
//   held back.
//   Path: a read result passes the front register, the queue and the back
//   end's pop and execute states; commands queued ahead delay it further.
//   Pacing: the back end finishes one command before it pops the next, set by
//   its read-then-write of the histogram memory (single port, registered read).
//   Ignored records (zero submit time, unknown kind) and unused op codes
//   stop in the front, never queued. A 2-entry queue decouples front and
//   back; busy rises only when the queue is full and the front holds a beat.
//   Reset (synchronous, active low) zeroes all statistics at once through
//   per-entry valid bits on the histogram memory; no clearing pass needed.
// ----------------------------------------------------------------------------
module latency_histogram_monitor_unit import lhm_pkg::*; #(
    parameter int NUM_KINDS   = LHM_NUM_KINDS,
    parameter int NUM_BUCKETS = LHM_NUM_BUCKETS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_op,
    input  logic [LHM_KIND_W-1:0] i_kind,
    input  logic [LHM_TIME_W-1:0] i_submit_time,
    input  logic [LHM_TIME_W-1:0] i_now_time,
    input  logic [LHM_SEL_W-1:0]  i_bucket_sel,
    output logic                  o_valid,
    output logic [LHM_TIME_W-1:0] o_event_count,
    output logic [LHM_TIME_W-1:0] o_elapsed_sum,
    output logic [LHM_TIME_W-1:0] o_elapsed_max,
    output logic [LHM_TIME_W-1:0] o_bucket_count
);

    logic     w_accept;
    logic     w_push;
    logic     w_pop;
    logic     w_q_full;
    logic     w_q_empty;
    logic     w_stall;
    t_q_entry w_front_entry;
    t_q_entry w_back_entry;

    // a command beat is taken whenever the front stage can move on
    assign w_accept = start && !w_stall;
    assign busy     = w_stall;

    // front: elapsed time, bucket index and histogram address
    lhm_front #(
        .NUM_KINDS   (NUM_KINDS),
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_op          (i_op),
        .i_kind        (i_kind),
        .i_submit_time (i_submit_time),
        .i_now_time    (i_now_time),
        .i_bucket_sel  (i_bucket_sel),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_entry       (w_front_entry),
        .o_stall       (w_stall)
    );

    // in-order command queue; keeps records, reads and clears ordered
    lhm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .i_pop   (w_pop),
        .o_entry (w_back_entry),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    // back: read-modify-write of the stores and result beats
    lhm_back #(
        .NUM_KINDS   (NUM_KINDS),
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (w_back_entry),
        .i_empty        (w_q_empty),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .o_event_count  (o_event_count),
        .o_elapsed_sum  (o_elapsed_sum),
        .o_elapsed_max  (o_elapsed_max),
        .o_bucket_count (o_bucket_count)
    );

endmodule

// ----- src/lhm_checker.sv -----
// ----------------------------------------------------------------------------
// lhm_checker
// Port-level checks for the latency histogram monitor, bound to the top.
// ----------------------------------------------------------------------------
module lhm_checker import lhm_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_valid,
    input logic [LHM_TIME_W-1:0] o_event_count,
    input logic [LHM_TIME_W-1:0] o_elapsed_sum,
    input logic [LHM_TIME_W-1:0] o_elapsed_max,
    input logic [LHM_TIME_W-1:0] o_bucket_count
);

    // reset leaves the block idle with no result beat
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("result or busy right after reset");

    // the back end returns to idle after each command, so result beats are never adjacent
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beats in consecutive cycles");

    // no events recorded means every statistic is zero
    a_empty_kind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_count == '0) |->
            (o_elapsed_sum == '0) && (o_elapsed_max == '0) && (o_bucket_count == '0))
        else $error("nonzero statistics with zero event count");

    // one bucket never holds more events than the kind has
    a_bucket_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bucket_count <= o_event_count))
        else $error("bucket count above event count");

    // busy only follows a command beat or an earlier busy cycle
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> $past(start) || $past(busy))
        else $error("busy without a pending command");

endmodule

bind latency_histogram_monitor_unit lhm_checker u_lhm_checker (.*);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for latency_histogram_monitor_unit. Commands go in
// through start/busy, and a scoreboard keeps its own copy of the per-kind
// count, sum, max and log2 histogram to predict every read beat. A short
// directed run hits the corner cases first. Random traffic follows: mostly
// well-formed records with latencies spread over all buckets, then reads,
// with a few clears and unused op codes mixed in.
// ----------------------------------------------------------------------------
module tb import lhm_pkg::*; ();

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         RAND_BEATS = 1050;
    localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

    // One read beat as it leaves the block
    typedef struct packed {
        logic [63:0] count;
        logic [63:0] sum;
        logic [63:0] peak;
        logic [63:0] bucket;
    } t_stat_beat;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow statistics plus a queue of pending read beats
    // ------------------------------------------------------------------------
    class t_stats_scoreboard;
        logic [63:0] count_by_kind [LHM_NUM_KINDS];
        logic [63:0] sum_by_kind   [LHM_NUM_KINDS];
        logic [63:0] peak_by_kind  [LHM_NUM_KINDS];
        logic [63:0] hist          [LHM_NUM_KINDS][LHM_NUM_BUCKETS];
        t_stat_beat  pending_reads [$];
        int          errors;

        function new();
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (count_by_kind[k]) begin
                count_by_kind[k] = '0;
                sum_by_kind[k]   = '0;
                peak_by_kind[k]  = '0;
            end
            foreach (hist[k, b]) hist[k][b] = '0;
        endfunction

        // floor(log2(v)); 0 and 1 both land in bucket 0, top bucket saturates
        function int log2_bucket(logic [63:0] v);
            int idx;
            idx = 0;
            for (int i = 1; i < 64; i++) if (v[i]) idx = i;
            if (idx > LHM_NUM_BUCKETS - 1) idx = LHM_NUM_BUCKETS - 1;
            return idx;
        endfunction

        // Called on every accepted command beat
        function void note_cmd(logic [1:0] op, logic [LHM_KIND_W-1:0] kind,
                               logic [63:0] submit, logic [63:0] now,
                               logic [LHM_SEL_W-1:0] sel);
            logic [63:0] elapsed;
            t_stat_beat  beat;
            int          k;
            k = int'(kind);
            if (op == OP_RECORD) begin
                // zero submit stamp or unknown kind: dropped silently
                if (submit != '0 && k < LHM_NUM_KINDS) begin
                    elapsed = (now > submit) ? now - submit : '0;
                    count_by_kind[k] += 64'd1;
                    sum_by_kind[k]   += elapsed;
                    if (elapsed > peak_by_kind[k]) peak_by_kind[k] = elapsed;
                    hist[k][log2_bucket(elapsed)] += 64'd1;
                end
            end else if (op == OP_READ) begin
                beat = '0;
                if (k < LHM_NUM_KINDS) begin
                    beat.count = count_by_kind[k];
                    beat.sum   = sum_by_kind[k];
                    beat.peak  = peak_by_kind[k];
                    if (int'(sel) < LHM_NUM_BUCKETS) beat.bucket = hist[k][int'(sel)];
                end
                pending_reads.push_back(beat);
            end else if (op == OP_CLEAR) begin
                wipe();
            end
            // unused op code: no effect
        endfunction

        task report(string msg);
            $display("tb: MISMATCH %s", msg);
            errors++;
        endtask

        task check_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got %h want %h", name, got, want));
        endtask

        // Called on every result strobe
        task check_result(t_stat_beat got);
            t_stat_beat want;
            if (pending_reads.size() == 0) begin
                report($sformatf("unexpected result beat count=%h", got.count));
            end else begin
                want = pending_reads.pop_front();
                check_field("event_count",  got.count,  want.count);
                check_field("elapsed_sum",  got.sum,    want.sum);
                check_field("elapsed_max",  got.peak,   want.peak);
                check_field("bucket_count", got.bucket, want.bucket);
            end
        endtask

        function int outstanding();
            return pending_reads.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            i_op;
    logic [LHM_KIND_W-1:0] i_kind;
    logic [LHM_TIME_W-1:0] i_submit_time;
    logic [LHM_TIME_W-1:0] i_now_time;
    logic [LHM_SEL_W-1:0]  i_bucket_sel;
    logic                  o_valid;
    logic [LHM_TIME_W-1:0] o_event_count;
    logic [LHM_TIME_W-1:0] o_elapsed_sum;
    logic [LHM_TIME_W-1:0] o_elapsed_max;
    logic [LHM_TIME_W-1:0] o_bucket_count;

    t_stats_scoreboard sb;
    bit                burst_mode;

    latency_histogram_monitor_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_kind         (i_kind),
        .i_submit_time  (i_submit_time),
        .i_now_time     (i_now_time),
        .i_bucket_sel   (i_bucket_sel),
        .o_valid        (o_valid),
        .o_event_count  (o_event_count),
        .o_elapsed_sum  (o_elapsed_sum),
        .o_elapsed_max  (o_elapsed_max),
        .o_bucket_count (o_bucket_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the handshake hangs
    initial begin
        #3000000;
        $display("tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitor: both sides sampled at the rising edge. A read result can never
    // show up in the cycle its command is taken, so the order below is safe.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_cmd(i_op, i_kind, i_submit_time, i_now_time, i_bucket_sel);
            if (o_valid)
                sb.check_result({o_event_count, o_elapsed_sum, o_elapsed_max,
                                 o_bucket_count});
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Drive one command beat after an idle gap; returns once it is taken.
    // start only drops during a gap, so back-to-back beats keep it high.
    task automatic send_cmd(logic [1:0] op, logic [LHM_KIND_W-1:0] kind,
                            logic [63:0] submit, logic [63:0] now,
                            logic [LHM_SEL_W-1:0] sel, int gap);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_op          <= op;
        i_kind        <= kind;
        i_submit_time <= submit;
        i_now_time    <= now;
        i_bucket_sel  <= sel;
        do @(posedge i_clk); while (busy);
    endtask

    // Gap before the next beat; bursts run with no idle at all
    function automatic int next_gap();
        return burst_mode ? 0 : $urandom_range(0, 15);
    endfunction

    // Record with a latency aimed at a chosen log2 bucket, or one of the
    // odd cases: zero submit, now not later than submit, raw random stamps.
    task automatic send_random_record(ref int counted);
        logic [63:0] submit;
        logic [63:0] now;
        logic [63:0] elapsed;
        int          b;
        int          mode;
        mode = $urandom_range(0, 11);
        if (mode == 0) begin
            submit = '0;
            now    = rand64();
        end else if (mode == 1) begin
            now    = rand64();
            submit = now + $urandom_range(0, 3);
            if (submit == '0) submit = 64'd1;
            counted++;
        end else if (mode == 2) begin
            submit = rand64() | 64'd1;
            now    = rand64();
            counted++;
        end else begin
            b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                            : $urandom_range(0, 33);
            elapsed = (64'd1 << b) | (rand64() & ((64'd1 << b) - 64'd1));
            if (elapsed == ALL_ONES) elapsed = elapsed - 64'd1;
            submit = (rand64() % (~elapsed)) + 64'd1;
            now    = submit + elapsed;
            counted++;
        end
        send_cmd(OP_RECORD, 2'($urandom_range(0, 3)), submit, now,
                 5'($urandom), next_gap());
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int counted;
        int pick;
        int waited;

        sb            = new();
        burst_mode    = 1'b1;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_op          = '0;
        i_kind        = '0;
        i_submit_time = '0;
        i_now_time    = '0;
        i_bucket_sel  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, back to back so record-then-read runs with no gap between commands
        send_cmd(OP_READ,   2'd0, '0,        '0,        5'd0,  0); // fresh stores
        send_cmd(OP_RECORD, 2'd0, 64'd100,   64'd100,   5'd0,  0); // elapsed 0
        send_cmd(OP_RECORD, 2'd0, 64'd100,   64'd101,   5'd0,  0); // elapsed 1
        send_cmd(OP_RECORD, 2'd0, 64'd5,     64'd3,     5'd0,  0); // now earlier
        send_cmd(OP_RECORD, 2'd0, '0,        64'd1000,  5'd0,  0); // zero submit
        send_cmd(OP_READ,   2'd0, ALL_ONES,  ALL_ONES,  5'd0,  0);
        send_cmd(OP_RECORD, 2'd1, 64'd1,     ALL_ONES,  5'd31, 0); // biggest latency
        send_cmd(OP_RECORD, 2'd1, 64'd1,     ALL_ONES,  5'd31, 0); // sum wraps
        send_cmd(OP_READ,   2'd1, '0,        '0,        5'd31, 0);
        send_cmd(OP_RECORD, 2'd2, 64'd1, 64'd1 + (64'd1 << 31), 5'd0, 0); // top bucket
        send_cmd(OP_RECORD, 2'd2, 64'd1, 64'd1 << 31,          5'd0, 0); // one below
        send_cmd(OP_READ,   2'd2, '0,        '0,        5'd31, 0);
        send_cmd(OP_READ,   2'd2, '0,        '0,        5'd30, 0);
        send_cmd(OP_UNUSED, 2'd3, 64'd7,     64'd900,   5'd3,  0); // ignored op
        send_cmd(OP_RECORD, 2'd3, ALL_ONES,  ALL_ONES,  5'd0,  0);
        send_cmd(OP_RECORD, 2'd3, 64'd2,     64'd6,     5'd2,  0);
        send_cmd(OP_READ,   2'd3, '0,        '0,        5'd2,  0);
        send_cmd(OP_READ,   2'd3, '0,        '0,        5'd0,  0);
        send_cmd(OP_CLEAR,  2'd0, '0,        '0,        5'd0,  0);
        send_cmd(OP_READ,   2'd1, '0,        '0,        5'd31, 0); // cleared
        send_cmd(OP_RECORD, 2'd1, 64'd10,    64'd13,    5'd1,  3);
        send_cmd(OP_READ,   2'd1, '0,        '0,        5'd1,  0);

        // Random traffic; ignored records and unused ops don't count
        counted = 0;
        while (counted < RAND_BEATS) begin
            if ($urandom_range(0, 49) == 0) burst_mode = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_random_record(counted);
            end else if (pick < 94) begin
                send_cmd(OP_READ, 2'($urandom_range(0, 3)), rand64(), rand64(),
                         5'($urandom), next_gap());
                counted++;
            end else if (pick < 96) begin
                send_cmd(OP_CLEAR, 2'($urandom), rand64(), rand64(),
                         5'($urandom), next_gap());
                counted++;
            end else begin
                send_cmd(OP_UNUSED, 2'($urandom), rand64(), rand64(),
                         5'($urandom), next_gap());
            end
        end
        @(negedge i_clk);
        start <= 1'b0;

        // Drain: wait, with a bound, until every pending read result has come back
        waited = 0;
        while (sb.outstanding() > 0 && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (16) @(posedge i_clk);
        if (sb.outstanding() > 0)
            sb.report($sformatf("%0d read results never arrived", sb.outstanding()));

        if (sb.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/lhm_pkg.sv
src/lhm_front.sv
src/lhm_queue.sv
src/lhm_back.sv
src/latency_histogram_monitor_unit.sv
src/lhm_checker.sv
sim/tb.sv
